FILE: src/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds command codes, special character codes and the screen cell layout.
// No dependencies.
package tcw_pkg;

  // Command codes carried on the cmd port.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  // Attribute written by the power-on clearing pass.
  localparam logic [7:0] RESET_ATTR = 8'd7;

  // Port widths of the cursor fields.
  localparam int OFFSET_PORT_W = 11;
  localparam int COLUMN_PORT_W = 7;
  localparam int ROW_PORT_W    = 5;

  // One screen cell: attribute in the high byte, character in the low byte.
  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] code;
  } cell_t;

endpackage

FILE: src/tcw_screen_ram.sv
// Screen store of the text console writer: one write port, one registered read port.
// Depends on tcw_pkg for the cell type.
module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  tcw_pkg::cell_t      wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output tcw_pkg::cell_t      rdata
);

  tcw_pkg::cell_t mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tcw_mod_unit.sv
// Remainder unit: value modulo a constant divisor by reciprocal multiplication.
// No package dependencies; used by the top level for tab stops.
module tcw_mod_unit #(
  parameter int VALUE_W = 11,
  parameter int DIVISOR = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [VALUE_W-1:0]         value,
  output logic                       done,
  output logic [$clog2(DIVISOR)-1:0] rem
);

  localparam int REM_W   = $clog2(DIVISOR);
  localparam int SHIFT   = VALUE_W + REM_W;
  localparam int RECIP_W = VALUE_W + 1;
  localparam int PROD_W  = VALUE_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - SHIFT;

  // Rounded-up reciprocal of the divisor; with this shift the quotient is exact for
  // every value that fits in VALUE_W bits.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR));

  logic [VALUE_W-1:0] value_hold;
  logic [QUOT_W-1:0]  quot;
  logic               pending;
  logic [PROD_W-1:0]  product;

  // Reciprocal product of the incoming value; its top bits are the quotient.
  assign product = PROD_W'(value) * PROD_W'(RECIP);

  // Control: done follows the start pulse through the pending register, with the remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      done    <= 1'b0;
    end else begin
      pending <= start;
      done    <= pending;
    end
  end

  // Quotient registered on start, remainder by multiply and subtract while pending.
  always_ff @(posedge clk) begin
    if (start) begin
      value_hold <= value;
      quot       <= product[PROD_W-1:SHIFT];
    end
    if (pending) begin
      rem <= REM_W'(value_hold - VALUE_W'(quot * DIVISOR));
    end
  end

endmodule

FILE: src/text_console_writer_core.sv
// Top level of the text console writer: command sequencer, cursor and screen store.
// Depends on tcw_pkg, tcw_screen_ram and tcw_mod_unit.

// A command beat is taken when start is high and busy is low; its one result appears
// on the result ports with done high for a single cycle and must be captured then.
// A printable character or newline goes through S_PUT to done, set cursor through
// S_ADDR, read cell through S_ADDR, S_READ and S_RDATA (address multiply, then the
// registered store read). A tab finds the cursor offset modulo TAB_STOP in the
// remainder unit (a reciprocal multiply), then steps the cursor one cell per cycle,
// up to TAB_STOP steps, unless it scrolls first. A scroll copies each cell of the
// store up one row in a read state and a write state (S_SCR_RD, then S_SCR_WR) and
// blanks the last row at one cell per cycle; clear screen writes one cell per cycle.
// After reset a clearing pass fills the store with spaces in attribute 7, with busy
// high; attribute writes are taken at any time, including then.
module text_console_writer_core #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] char_code,
  input  logic [6:0] column,
  input  logic [4:0] row,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output logic       done,
  output logic [10:0] cursor_offset,
  output logic [6:0] cursor_column,
  output logic [4:0] cursor_row,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic       scrolled
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int OFF_W = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int REM_W = $clog2(TAB_STOP);
  localparam int DEL_W = $clog2(TAB_STOP + 1);
  localparam int OFF_X = (OFF_W > tcw_pkg::OFFSET_PORT_W) ? OFF_W : tcw_pkg::OFFSET_PORT_W;
  localparam int COL_X = (COL_W > tcw_pkg::COLUMN_PORT_W) ? COL_W : tcw_pkg::COLUMN_PORT_W;
  localparam int ROW_X = (ROW_W > tcw_pkg::ROW_PORT_W) ? ROW_W : tcw_pkg::ROW_PORT_W;

  localparam logic [OFF_W-1:0] LAST_CELL   = OFF_W'(CELLS - 1);
  localparam logic [OFF_W-1:0] LAST_COPY   = OFF_W'(CELLS - COLUMNS - 1);
  localparam logic [OFF_W-1:0] SCROLL_BASE = OFF_W'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0] LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PUT     = 4'd1;
  localparam logic [3:0] S_TABREM  = 4'd2;
  localparam logic [3:0] S_TABSTEP = 4'd3;
  localparam logic [3:0] S_ADDR    = 4'd4;
  localparam logic [3:0] S_READ    = 4'd5;
  localparam logic [3:0] S_RDATA   = 4'd6;
  localparam logic [3:0] S_SCR_RD  = 4'd7;
  localparam logic [3:0] S_SCR_WR  = 4'd8;
  localparam logic [3:0] S_FILL    = 4'd9;

  logic [3:0]       state;
  logic [7:0]       text_attribute;
  logic [1:0]       cmd_hold;
  logic [7:0]       char_hold;
  logic [6:0]       column_hold;
  logic [4:0]       row_hold;
  logic [OFF_W-1:0] cur_off;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [OFF_W-1:0] addr;
  logic [OFF_W-1:0] count;
  logic [DEL_W-1:0] steps;
  logic [7:0]       fill_attr;
  logic             fill_report;
  logic             fill_scrolled;
  logic [7:0]       res_char;
  logic [7:0]       res_attr;
  logic             res_scrolled;

  // Advance step shared by printable characters and tab steps.
  logic [OFF_W-1:0] adv_off;
  logic [COL_W-1:0] adv_col;
  logic [ROW_W-1:0] adv_row;
  logic             adv_end;

  // Clamped coordinates and their linear address.
  logic [COL_X-1:0] col_ext;
  logic [ROW_X-1:0] row_ext;
  logic [COL_W-1:0] col_clamp;
  logic [ROW_W-1:0] row_clamp;
  logic [OFF_W-1:0] addr_calc;

  // Store ports and remainder unit.
  logic             ram_we;
  logic [OFF_W-1:0] ram_waddr;
  tcw_pkg::cell_t   ram_wdata;
  logic [OFF_W-1:0] ram_raddr;
  tcw_pkg::cell_t   ram_rdata;
  logic             mod_start;
  logic             mod_done;
  logic [REM_W-1:0] mod_rem;
  logic             accept;
  logic [OFF_X-1:0] off_port;
  logic [COL_X-1:0] col_port;
  logic [ROW_X-1:0] row_port;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    adv_end = 1'b0;
    adv_off = cur_off + OFF_W'(1);
    adv_col = cur_col + COL_W'(1);
    adv_row = cur_row;
    if (cur_col == LAST_COL) begin
      adv_col = '0;
      adv_row = cur_row + ROW_W'(1);
      adv_end = (cur_row == LAST_ROW);
    end
  end

  always_comb begin
    col_ext   = COL_X'(column_hold);
    row_ext   = ROW_X'(row_hold);
    col_clamp = (col_ext > COL_X'(COLUMNS - 1)) ? LAST_COL : COL_W'(col_ext);
    row_clamp = (row_ext > ROW_X'(ROWS - 1)) ? LAST_ROW : ROW_W'(row_ext);
    addr_calc = OFF_W'(row_clamp * COLUMNS) + OFF_W'(col_clamp);
  end

  // Store write and read selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count;
    ram_wdata = '{attr: fill_attr, code: tcw_pkg::CHAR_SPACE};
    unique case (state)
      S_PUT: begin
        ram_we    = (char_hold != tcw_pkg::CHAR_NEWLINE) && (char_hold != tcw_pkg::CHAR_TAB);
        ram_waddr = cur_off;
        ram_wdata = '{attr: text_attribute, code: char_hold};
      end
      S_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = (state == S_SCR_RD) ? (count + OFF_W'(COLUMNS)) : addr;
  assign mod_start = (state == S_PUT) && (char_hold == tcw_pkg::CHAR_TAB);

  tcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (OFF_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_mod_unit #(
    .VALUE_W (OFF_W),
    .DIVISOR (TAB_STOP)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (cur_off),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Attribute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tcw_pkg::RESET_ATTR;
    end else if (cfg_write) begin
      text_attribute <= cfg_data;
    end
  end

  // Command beat capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_hold    <= cmd;
      char_hold   <= char_code;
      column_hold <= column;
      row_hold    <= row;
    end
  end

  // Sequencer, cursor and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL;
      count         <= '0;
      fill_attr     <= tcw_pkg::RESET_ATTR;
      fill_report   <= 1'b0;
      fill_scrolled <= 1'b0;
      cur_off       <= '0;
      cur_col       <= '0;
      cur_row       <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              tcw_pkg::CMD_PUT: state <= S_PUT;
              tcw_pkg::CMD_SET: state <= S_ADDR;
              tcw_pkg::CMD_READ: state <= S_ADDR;
              tcw_pkg::CMD_CLEAR: begin
                state         <= S_FILL;
                count         <= '0;
                fill_attr     <= text_attribute;
                fill_report   <= 1'b1;
                fill_scrolled <= 1'b0;
                cur_off       <= '0;
                cur_col       <= '0;
                cur_row       <= '0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PUT: begin
          if (char_hold == tcw_pkg::CHAR_TAB) begin
            state <= S_TABREM;
          end else if ((char_hold == tcw_pkg::CHAR_NEWLINE) ? (cur_row == LAST_ROW) : adv_end) begin
            state         <= S_SCR_RD;
            count         <= '0;
            fill_attr     <= text_attribute;
            fill_report   <= 1'b1;
            fill_scrolled <= 1'b1;
            cur_off       <= SCROLL_BASE;
            cur_col       <= '0;
            cur_row       <= LAST_ROW;
          end else begin
            if (char_hold == tcw_pkg::CHAR_NEWLINE) begin
              cur_off <= cur_off + OFF_W'(COLUMNS) - OFF_W'(cur_col);
              cur_col <= '0;
              cur_row <= cur_row + ROW_W'(1);
            end else begin
              cur_off <= adv_off;
              cur_col <= adv_col;
              cur_row <= adv_row;
            end
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_TABREM: begin
          if (mod_done) begin
            steps <= DEL_W'(TAB_STOP) - DEL_W'(mod_rem);
            state <= S_TABSTEP;
          end
        end
        S_TABSTEP: begin
          if (adv_end) begin
            state         <= S_SCR_RD;
            count         <= '0;
            fill_attr     <= text_attribute;
            fill_report   <= 1'b1;
            fill_scrolled <= 1'b1;
            cur_off       <= SCROLL_BASE;
            cur_col       <= '0;
            cur_row       <= LAST_ROW;
          end else begin
            cur_off <= adv_off;
            cur_col <= adv_col;
            cur_row <= adv_row;
            steps   <= steps - DEL_W'(1);
            if (steps == DEL_W'(1)) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end
          end
        end
        S_ADDR: begin
          addr <= addr_calc;
          if (cmd_hold == tcw_pkg::CMD_SET) begin
            cur_off <= addr_calc;
            cur_col <= col_clamp;
            cur_row <= row_clamp;
            state   <= S_IDLE;
            done    <= 1'b1;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_RDATA;
        end
        S_RDATA: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_SCR_RD: begin
          state <= S_SCR_WR;
        end
        S_SCR_WR: begin
          if (count == LAST_COPY) begin
            state <= S_FILL;
          end else begin
            state <= S_SCR_RD;
          end
          count <= count + OFF_W'(1);
        end
        S_FILL: begin
          if (count == LAST_CELL) begin
            state <= S_IDLE;
            done  <= fill_report;
          end else begin
            count <= count + OFF_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload: cell contents only for a read, scroll flag only after a scroll.
  always_ff @(posedge clk) begin
    if (state == S_RDATA) begin
      res_char     <= ram_rdata.code;
      res_attr     <= ram_rdata.attr;
      res_scrolled <= 1'b0;
    end else if (state == S_FILL) begin
      res_char     <= '0;
      res_attr     <= '0;
      res_scrolled <= fill_scrolled;
    end else begin
      res_char     <= '0;
      res_attr     <= '0;
      res_scrolled <= 1'b0;
    end
  end

  // Cursor fields, cut or widened to the port widths.
  assign off_port      = OFF_X'(cur_off);
  assign col_port      = COL_X'(cur_col);
  assign row_port      = ROW_X'(cur_row);
  assign cursor_offset = off_port[tcw_pkg::OFFSET_PORT_W-1:0];
  assign cursor_column = col_port[tcw_pkg::COLUMN_PORT_W-1:0];
  assign cursor_row    = row_port[tcw_pkg::ROW_PORT_W-1:0];
  assign cell_char     = res_char;
  assign cell_attr     = res_attr;
  assign scrolled      = res_scrolled;

`ifndef SYNTHESIS
  // A result beat only ever appears once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // An accepted command always makes the sequencer busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("command accepted without work");

  // The cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_off <= LAST_CELL) && (cur_col <= LAST_COL) && (cur_row <= LAST_ROW))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the last row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (done && res_scrolled) |-> ((cur_off == SCROLL_BASE) && (cur_col == '0)))
    else $error("cursor wrong after scroll");
`endif

endmodule

FILE: tb/tb_text_console_writer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer_core: put, set cursor, clear and read.
// Keeps its own copy of the screen and cursor and checks every result beat.
// Depends on tcw_pkg and text_console_writer_core.
module tb_text_console_writer_core;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // One command beat, laid out as the ports are.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] code;
    logic [6:0] col;
    logic [4:0] row;
  } console_cmd_t;

  localparam int CMD_BITS = $bits(console_cmd_t);

  // One result beat.
  typedef struct packed {
    logic [tcw_pkg::OFFSET_PORT_W-1:0] offset;
    logic [tcw_pkg::COLUMN_PORT_W-1:0] col;
    logic [tcw_pkg::ROW_PORT_W-1:0]    row;
    logic [7:0]                        code;
    logic [7:0]                        attr;
    logic                              scrolled;
  } console_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  cmd = tcw_pkg::CMD_PUT;
  logic [7:0]  char_code = '0;
  logic [6:0]  column = '0;
  logic [4:0]  row = '0;
  logic        cfg_write = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        busy;
  logic        done;
  logic [10:0] cursor_offset;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic        scrolled;

  text_console_writer_core #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .char_code     (char_code),
    .column        (column),
    .row           (row),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .cursor_offset (cursor_offset),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row),
    .cell_char     (cell_char),
    .cell_attr     (cell_attr),
    .scrolled      (scrolled)
  );

  // 4 ns clock.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Shadow copy of the console state.
  tcw_pkg::cell_t screen_model [CELL_COUNT];
  int unsigned    cursor_pos;
  logic [7:0]     text_attr;

  console_cmd_t    pending_cmds [$];
  console_report_t awaited_reports [$];
  int              mismatch_count = 0;
  logic            beat_taken = 1'b0;
  int              burst_left = 0;
  int              gap_left = 0;

  // Linear cell index with both coordinates saturated to the screen.
  function automatic int unsigned cell_index(logic [6:0] col, logic [4:0] row_sel);
    int unsigned c;
    int unsigned r;
    c = (col > COLUMNS - 1) ? COLUMNS - 1 : col;
    r = (row_sel > ROWS - 1) ? ROWS - 1 : row_sel;
    return r * COLUMNS + c;
  endfunction

  // Applies one command to the shadow state and returns the report it should produce.
  function automatic console_report_t console_step(console_cmd_t c);
    console_report_t rep;
    int unsigned     pos;
    int unsigned     i;
    tcw_pkg::cell_t  stored;
    rep = '0;
    pos = cursor_pos;
    case (c.op)
      tcw_pkg::CMD_PUT: begin
        if (c.code == tcw_pkg::CHAR_NEWLINE) begin
          pos = pos + COLUMNS - pos % COLUMNS;
        end else if (c.code == tcw_pkg::CHAR_TAB) begin
          pos = pos + TAB_STOP - pos % TAB_STOP;
        end else begin
          screen_model[pos] = {text_attr, c.code};
          pos++;
        end
        // Running off the end shifts everything up a row and blanks the last one.
        if (pos >= CELL_COUNT) begin
          for (i = 0; i < CELL_COUNT - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
            screen_model[i] = {text_attr, tcw_pkg::CHAR_SPACE};
          end
          pos = CELL_COUNT - COLUMNS;
          rep.scrolled = 1'b1;
        end
      end
      tcw_pkg::CMD_SET: begin
        pos = cell_index(c.col, c.row);
      end
      tcw_pkg::CMD_CLEAR: begin
        for (i = 0; i < CELL_COUNT; i++) screen_model[i] = {text_attr, tcw_pkg::CHAR_SPACE};
        pos = 0;
      end
      default: begin
        stored = screen_model[cell_index(c.col, c.row)];
        rep.code = stored.code;
        rep.attr = stored.attr;
      end
    endcase
    cursor_pos = pos;
    rep.offset = tcw_pkg::OFFSET_PORT_W'(pos);
    rep.col    = tcw_pkg::COLUMN_PORT_W'(pos % COLUMNS);
    rep.row    = tcw_pkg::ROW_PORT_W'(pos / COLUMNS);
    return rep;
  endfunction

  task automatic check_field(string label, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Sender: issues queued commands in bursts, with random gaps between bursts.
  always @(negedge clk) begin : cmd_driver
    console_cmd_t next_cmd;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        start     <= 1'b1;
        cmd       <= next_cmd.op;
        char_code <= next_cmd.code;
        column    <= next_cmd.col;
        row       <= next_cmd.row;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(7) == 0) ? $urandom_range(300, 50) : $urandom_range(12, 1);
        end
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(5) == 0) ? $urandom_range(40, 8) : $urandom_range(4);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat, then predicts the result of any command taken.
  always @(posedge clk) begin : report_monitor
    console_report_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      if (done) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t ns: result beat with no command outstanding, expected none, actual %0d",
                   $time, cursor_offset);
          mismatch_count++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("cursor_offset", want.offset, cursor_offset);
          check_field("cursor_column", 11'(want.col), 11'(cursor_column));
          check_field("cursor_row", 11'(want.row), 11'(cursor_row));
          check_field("cell_char", 11'(want.code), 11'(cell_char));
          check_field("cell_attr", 11'(want.attr), 11'(cell_attr));
          check_field("scrolled", 11'(want.scrolled), 11'(scrolled));
        end
      end
      beat_taken <= start && !busy;
      if (start && !busy) begin
        awaited_reports.push_back(console_step({cmd, char_code, column, row}));
      end
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] code, logic [6:0] col, logic [4:0] row_sel);
    pending_cmds.push_back({op, code, col, row_sel});
  endtask

  // Waits until nothing is queued, in flight or outstanding.
  task automatic wait_until_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || start || awaited_reports.size() != 0 || busy);
  endtask

  // Attribute writes happen only while the block is idle.
  task automatic write_attribute(logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    text_attr = value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Positions the cursor, types a short run of characters and reads some of them back.
  task automatic queue_typing_run();
    logic [6:0]  c;
    logic [4:0]  r;
    logic [7:0]  code;
    int          len;
    int          j;
    if ($urandom_range(9) == 0) begin
      c = 7'($urandom_range(COLUMNS - 1, COLUMNS - 14));
      r = 5'(ROWS - 1);
    end else begin
      c = 7'($urandom_range(COLUMNS - 1));
      r = 5'($urandom_range(ROWS - 1));
    end
    send(tcw_pkg::CMD_SET, 8'($urandom), c, r);
    len = $urandom_range(12, 1);
    for (j = 0; j < len; j++) begin
      code = 8'($urandom_range(255));
      case ($urandom_range(15))
        0: code = tcw_pkg::CHAR_NEWLINE;
        1: code = tcw_pkg::CHAR_TAB;
        default: ;
      endcase
      send(tcw_pkg::CMD_PUT, code, 7'($urandom), 5'($urandom));
    end
    repeat ($urandom_range(2)) begin
      send(tcw_pkg::CMD_READ, 8'($urandom), 7'(c + $urandom_range(len - 1)), r);
    end
  endtask

  // Stray command with every field random; clears are kept rare as they are slow.
  function automatic console_cmd_t random_command();
    console_cmd_t c;
    c = CMD_BITS'($urandom);
    if (c.op == tcw_pkg::CMD_CLEAR && $urandom_range(3) != 0) c.op = tcw_pkg::CMD_PUT;
    return c;
  endfunction

  initial begin : stimulus
    logic [7:0] attr_plan [5];
    int         phase;
    int         i;
    attr_plan = '{8'hFF, 8'h00, 8'h00, 8'h80, 8'h00};
    attr_plan[2] = 8'($urandom);
    attr_plan[4] = 8'($urandom);
    for (i = 0; i < CELL_COUNT; i++) screen_model[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_SPACE};
    cursor_pos = 0;
    text_attr  = tcw_pkg::RESET_ATTR;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset attribute: extremes, controls, clamping and scrolls.
    send(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0);
    send(tcw_pkg::CMD_READ, 8'hFF, 7'd127, 5'd31);
    send(tcw_pkg::CMD_PUT, 8'h41, 7'd0, 5'd0);
    send(tcw_pkg::CMD_PUT, 8'h00, 7'd127, 5'd31);
    send(tcw_pkg::CMD_PUT, 8'hFF, 7'd0, 5'd0);
    send(tcw_pkg::CMD_READ, 8'h00, 7'd1, 5'd0);
    send(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, 7'd0, 5'd0);
    send(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_TAB, 7'd0, 5'd0);
    send(tcw_pkg::CMD_PUT, 8'h78, 7'd0, 5'd0);
    send(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_TAB, 7'd0, 5'd0);
    // Last cell of the screen, then a character that forces a scroll.
    send(tcw_pkg::CMD_SET, 8'h00, 7'd127, 5'd31);
    send(tcw_pkg::CMD_PUT, 8'h5A, 7'd0, 5'd0);
    send(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd23);
    send(tcw_pkg::CMD_READ, 8'h00, 7'd8, 5'd0);
    // Tab and newline that both run off the bottom row.
    send(tcw_pkg::CMD_SET, 8'h00, 7'd72, 5'd24);
    send(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_TAB, 7'd0, 5'd0);
    send(tcw_pkg::CMD_SET, 8'h00, 7'd5, 5'd24);
    send(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, 7'd0, 5'd0);
    send(tcw_pkg::CMD_SET, 8'h00, 7'd100, 5'd3);
    send(tcw_pkg::CMD_SET, 8'h00, 7'd3, 5'd30);
    send(tcw_pkg::CMD_CLEAR, 8'hFF, 7'd127, 5'd31);
    send(tcw_pkg::CMD_READ, 8'h00, 7'd10, 5'd10);
    send(tcw_pkg::CMD_SET, 8'h00, 7'd0, 5'd0);
    send(tcw_pkg::CMD_PUT, 8'h7F, 7'd0, 5'd0);
    send(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0);

    // Random phases, each under its own attribute; the sender drains fully in between.
    for (phase = 0; phase < 5; phase++) begin
      wait_until_drained();
      write_attribute(attr_plan[phase]);
      if (phase % 2 == 1) begin
        send(tcw_pkg::CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
      end
      while (pending_cmds.size() < 400) begin
        if ($urandom_range(9) < 7) queue_typing_run();
        else pending_cmds.push_back(random_command());
      end
    end

    wait_until_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit, well beyond the slowest run in which every command scrolls.
  initial begin : watchdog
    #(120_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
